/* src/ppu_register_and_scroll_timing_unit_defines.svh */
// Assertion helpers for the register and scroll timing unit.
`ifndef PPU_REGISTER_AND_SCROLL_TIMING_UNIT_DEFINES_SVH
`define PPU_REGISTER_AND_SCROLL_TIMING_UNIT_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted.
`define PRST_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prst assertion failed");

// Next-cycle implication, skipped while reset is asserted.
`define PRST_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prst assertion failed");

// Check that holds in the cycle after reset is seen low.
`define PRST_ASSERT_AFTER_RESET(name, clk, rstn, cons) \
    name: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("prst reset assertion failed");

`endif

/* src/prst_pkg.sv */
`default_nettype none

package prst_pkg;

    localparam int unsigned OBJ_BYTES  = 256;
    localparam int unsigned OBJ_ADDR_W = 8;
    localparam int unsigned NMI_CNT_W  = 4;

    localparam logic [8:0] LAST_DOT          = 9'd340;
    localparam logic [8:0] SKIP_DOT          = 9'd339;
    localparam logic [8:0] LAST_LINE         = 9'd261;
    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
    localparam logic [8:0] VBLANK_LINE       = 9'd241;
    localparam logic [8:0] VBLANK_DOT        = 9'd1;
    localparam logic [8:0] FETCH_FIRST_DOT   = 9'd1;
    localparam logic [8:0] FETCH_LAST_DOT    = 9'd256;
    localparam logic [8:0] PREFETCH_FIRST    = 9'd321;
    localparam logic [8:0] PREFETCH_LAST     = 9'd336;
    localparam logic [8:0] VCOPY_FIRST_DOT   = 9'd280;
    localparam logic [8:0] VCOPY_LAST_DOT    = 9'd304;
    localparam logic [8:0] FINE_Y_DOT        = 9'd256;
    localparam logic [8:0] HCOPY_DOT         = 9'd257;
    localparam logic [2:0] NT_PHASE          = 3'd1;
    localparam logic [2:0] AT_PHASE          = 3'd3;
    localparam logic [2:0] COARSE_X_PHASE    = 3'd0;

    localparam logic [15:0] VCOPY_KEEP  = 16'h841f;
    localparam logic [15:0] VCOPY_TAKE  = 16'h7be0;
    localparam logic [15:0] HCOPY_KEEP  = 16'hfbe0;
    localparam logic [15:0] HCOPY_TAKE  = 16'h041f;
    localparam logic [7:0]  ATTR_BYTE_MASK = 8'he3;
    localparam logic [1:0]  ATTR_BYTE_SLOT = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } prst_action_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OBJ_ADDR = 3'd3,
        REG_OBJ_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } prst_reg_t;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_DATA_READ  = 3'd1,
        KIND_DATA_WRITE = 3'd2,
        KIND_NT_FETCH   = 3'd3,
        KIND_AT_FETCH   = 3'd4
    } prst_kind_t;

    typedef struct packed {
        prst_action_t action;
        prst_reg_t    reg_select;
        logic [7:0]   write_data;
    } prst_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_error;
        prst_kind_t  access_kind;
        logic [15:0] access_address;
        logic [7:0]  access_data;
        logic        nmi_pulse;
        logic        frame_done;
        logic [2:0]  attr_shift;
    } prst_result_t;

    typedef struct packed {
        logic [8:0] dot;
        logic [8:0] line;
    } prst_pos_t;

    function automatic logic [15:0] coarse_x_up(input logic [15:0] v);
        logic [15:0] r;
        if (v[4:0] == 5'd31) begin
            r = {v[15:5], 5'd0} ^ 16'h0400;
        end else begin
            r = v + 16'd1;
        end
        return r;
    endfunction

    function automatic logic [15:0] fine_y_up(input logic [15:0] v);
        logic [15:0] r;
        logic [4:0]  row;
        r   = v;
        row = v[9:5];
        if (v[14:12] != 3'b111) begin
            r[14:12] = v[14:12] + 3'd1;
        end else begin
            r[14:12] = 3'd0;
            if (row == 5'd29) begin
                row   = 5'd0;
                r[11] = ~v[11];
            end else if (row == 5'd31) begin
                row = 5'd0;
            end else begin
                row = row + 5'd1;
            end
            r[9:5] = row;
        end
        return r;
    endfunction

    function automatic logic [15:0] nt_addr(input logic [15:0] v);
        return {4'b0010, v[11:0]};
    endfunction

    function automatic logic [15:0] at_addr(input logic [15:0] v);
        return {4'b0010, v[11:10], 4'b1111, v[9:7], v[4:2]};
    endfunction

endpackage

`default_nettype wire

/* src/ppu_register_and_scroll_timing_unit.sv */
// Picture processor register file and scroll/timing engine. Every input transfer is one
// dot tick, one register write or one register read (the spare action code does nothing
// and gives an all-zero result), and yields exactly one result transfer. The block takes
// one item per clock while the result side is not stalled: an input register feeds one
// stage of logic that updates all state and loads the result register, and the input side
// keeps accepting while a result waits as long as the result register drains. The object
// memory is a RAM with one write port and one registered read port whose read address is
// driven ahead from the next object pointer, so object data reads also run at full rate.
// Entries never written read as zero.
`default_nettype none

module ppu_register_and_scroll_timing_unit #(
    parameter int unsigned NMI_LAG = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // write_data
    input  wire logic [4:0]  s_tuser,   // action[1:0], reg_select[4:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // read_data, access_address, access_data,
                                        // nmi_pulse, frame_done, attr_shift, zero pad
    output logic      [3:0]  m_tuser    // read_error[0], access_kind[3:1]
);

    import prst_pkg::*;

    logic         in_valid_reg, in_valid_next;
    prst_item_t   item_reg;
    logic         out_valid_reg, out_valid_next;
    prst_result_t result_reg;
    prst_result_t result;
    logic         advance;
    logic         s_xfer;

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_xfer         = s_tvalid && s_tready;
    assign in_valid_next  = s_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    prst_core #(
        .NMI_LAG (NMI_LAG)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg.action     <= prst_action_t'(s_tuser[1:0]);
            item_reg.reg_select <= prst_reg_t'(s_tuser[4:2]);
            item_reg.write_data <= s_tdata;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg.attr_shift, result_reg.frame_done,
                       result_reg.nmi_pulse, result_reg.access_data,
                       result_reg.access_address, result_reg.read_data};
    assign m_tuser  = {result_reg.access_kind, result_reg.read_error};

endmodule

`default_nettype wire

/* src/prst_ram.sv */
`default_nettype none

module prst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/prst_timing.sv */
`default_nettype none

module prst_timing (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire logic                drawing,
    output prst_pkg::prst_pos_t      pos_next
);

    import prst_pkg::*;

    logic [8:0] dot_reg, line_reg;
    logic [8:0] dot_next, line_next;
    logic       odd_reg, odd_next;

    always_comb begin
        dot_next  = dot_reg;
        line_next = line_reg;
        odd_next  = odd_reg;
        if (drawing && odd_reg && line_reg == LAST_LINE && dot_reg == SKIP_DOT) begin
            dot_next  = '0;
            line_next = '0;
            odd_next  = 1'b0;
        end else if (dot_reg == LAST_DOT) begin
            dot_next = '0;
            if (line_reg == LAST_LINE) begin
                line_next = '0;
                odd_next  = ~odd_reg;
            end else begin
                line_next = line_reg + 9'd1;
            end
        end else begin
            dot_next = dot_reg + 9'd1;
        end
    end

    assign pos_next = '{dot: dot_next, line: line_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg  <= '0;
            line_reg <= '0;
            odd_reg  <= 1'b0;
        end else if (advance) begin
            dot_reg  <= dot_next;
            line_reg <= line_next;
            odd_reg  <= odd_next;
        end
    end

endmodule

`default_nettype wire

/* src/prst_core.sv */
`default_nettype none

module prst_core #(
    parameter int unsigned NMI_LAG = 15
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 fire,
    input  prst_pkg::prst_item_t      item,
    output prst_pkg::prst_result_t    result
);

    import prst_pkg::*;

    logic [7:0]            ctrl_reg, ctrl_next;
    logic [7:0]            mask_reg, mask_next;
    logic [7:0]            last_reg, last_next;
    logic [14:0]           temp_reg, temp_next;
    logic [15:0]           vptr_reg, vptr_next;
    logic [2:0]            fine_x_reg, fine_x_next;
    logic                  toggle_reg, toggle_next;
    logic [OBJ_ADDR_W-1:0] obj_ptr_reg, obj_ptr_next;
    logic                  vbl_reg, vbl_next;
    logic                  nmi_en_reg, nmi_en_next;
    logic                  nmi_prev_reg, nmi_prev_next;
    logic [NMI_CNT_W-1:0]  nmi_cnt_reg, nmi_cnt_next;
    logic [OBJ_BYTES-1:0]  obj_valid_reg;

    logic                  drawing;
    logic                  tick_fire;
    prst_pos_t             pos;
    logic                  obj_we;
    logic [7:0]            obj_wdata;
    logic [7:0]            obj_rdata;
    logic [OBJ_ADDR_W-1:0] obj_raddr;

    assign drawing   = |mask_reg[4:3];
    assign tick_fire = fire && item.action == ACT_TICK;
    assign obj_we    = fire && item.action == ACT_WRITE && item.reg_select == REG_OBJ_DATA;
    assign obj_wdata = (obj_ptr_reg[1:0] == ATTR_BYTE_SLOT) ?
                       (item.write_data & ATTR_BYTE_MASK) : item.write_data;
    assign obj_raddr = fire ? obj_ptr_next : obj_ptr_reg;

    prst_timing u_timing (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (tick_fire),
        .drawing  (drawing),
        .pos_next (pos)
    );

    prst_ram #(
        .WIDTH (8),
        .DEPTH (OBJ_BYTES)
    ) u_obj_ram (
        .aclk  (aclk),
        .we    (obj_we),
        .waddr (obj_ptr_reg),
        .wdata (obj_wdata),
        .raddr (obj_raddr),
        .rdata (obj_rdata)
    );

    always_comb begin
        logic        pre, vis, rl, fetch, edge_chk, lvl;
        logic [15:0] v;
        logic [15:0] step;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        last_next     = last_reg;
        temp_next     = temp_reg;
        vptr_next     = vptr_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        obj_ptr_next  = obj_ptr_reg;
        vbl_next      = vbl_reg;
        nmi_en_next   = nmi_en_reg;
        nmi_prev_next = nmi_prev_reg;
        nmi_cnt_next  = nmi_cnt_reg;
        result        = '0;
        edge_chk      = 1'b0;
        step          = ctrl_reg[2] ? 16'd32 : 16'd1;
        pre           = pos.line == LAST_LINE;
        vis           = pos.line <= LAST_VISIBLE_LINE;
        rl            = pre || vis;
        fetch         = (pos.dot >= PREFETCH_FIRST && pos.dot <= PREFETCH_LAST) ||
                        (pos.dot >= FETCH_FIRST_DOT && pos.dot <= FETCH_LAST_DOT);
        v             = vptr_reg;

        unique case (item.action)
            ACT_TICK: begin
                if (nmi_cnt_reg != '0) begin
                    nmi_cnt_next = nmi_cnt_reg - NMI_CNT_W'(1);
                    result.nmi_pulse = nmi_cnt_reg == NMI_CNT_W'(1) && nmi_en_reg && vbl_reg;
                end
                if (drawing) begin
                    if (rl && fetch) begin
                        if (pos.dot[2:0] == NT_PHASE) begin
                            result.access_kind    = KIND_NT_FETCH;
                            result.access_address = nt_addr(vptr_reg);
                        end else if (pos.dot[2:0] == AT_PHASE) begin
                            result.access_kind    = KIND_AT_FETCH;
                            result.access_address = at_addr(vptr_reg);
                            result.attr_shift     = {vptr_reg[6], vptr_reg[1], 1'b0};
                        end
                    end
                    if (pre && pos.dot >= VCOPY_FIRST_DOT && pos.dot <= VCOPY_LAST_DOT) begin
                        v = (v & VCOPY_KEEP) | ({1'b0, temp_reg} & VCOPY_TAKE);
                    end
                    if (rl) begin
                        if (fetch && pos.dot[2:0] == COARSE_X_PHASE) begin
                            v = coarse_x_up(v);
                        end
                        if (pos.dot == FINE_Y_DOT) begin
                            v = fine_y_up(v);
                        end
                        if (pos.dot == HCOPY_DOT) begin
                            v = (v & HCOPY_KEEP) | ({1'b0, temp_reg} & HCOPY_TAKE);
                        end
                    end
                    vptr_next = v;
                end
                if (pos.line == VBLANK_LINE && pos.dot == VBLANK_DOT) begin
                    vbl_next          = 1'b1;
                    edge_chk          = 1'b1;
                    result.frame_done = 1'b1;
                end else if (pre && pos.dot == VBLANK_DOT) begin
                    vbl_next = 1'b0;
                    edge_chk = 1'b1;
                end
            end
            ACT_WRITE: begin
                last_next = item.write_data;
                unique case (item.reg_select)
                    REG_CTRL: begin
                        ctrl_next         = item.write_data;
                        temp_next[11:10]  = item.write_data[1:0];
                        nmi_en_next       = item.write_data[7];
                        edge_chk          = 1'b1;
                    end
                    REG_MASK: begin
                        mask_next = item.write_data;
                    end
                    REG_STATUS: begin
                    end
                    REG_OBJ_ADDR: begin
                        obj_ptr_next = item.write_data;
                    end
                    REG_OBJ_DATA: begin
                        obj_ptr_next = obj_ptr_reg + OBJ_ADDR_W'(1);
                    end
                    REG_SCROLL: begin
                        if (toggle_reg) begin
                            temp_next[14:12] = item.write_data[2:0];
                            temp_next[9:5]   = item.write_data[7:3];
                            toggle_next      = 1'b0;
                        end else begin
                            temp_next[4:0] = item.write_data[7:3];
                            fine_x_next    = item.write_data[2:0];
                            toggle_next    = 1'b1;
                        end
                    end
                    REG_ADDR: begin
                        if (toggle_reg) begin
                            temp_next[7:0] = item.write_data;
                            vptr_next      = {1'b0, temp_reg[14:8], item.write_data};
                            toggle_next    = 1'b0;
                        end else begin
                            temp_next[14:8] = {1'b0, item.write_data[5:0]};
                            toggle_next     = 1'b1;
                        end
                    end
                    REG_DATA: begin
                        result.access_kind    = KIND_DATA_WRITE;
                        result.access_address = vptr_reg;
                        result.access_data    = item.write_data;
                        vptr_next             = vptr_reg + step;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_READ: begin
                unique case (item.reg_select)
                    REG_CTRL: begin
                        result.read_data = ctrl_reg;
                    end
                    REG_MASK: begin
                        result.read_data = mask_reg;
                    end
                    REG_STATUS: begin
                        result.read_data = {vbl_reg, 2'b00, last_reg[4:0]};
                        vbl_next         = 1'b0;
                        edge_chk         = 1'b1;
                        toggle_next      = 1'b0;
                    end
                    REG_OBJ_DATA: begin
                        result.read_data = obj_valid_reg[obj_ptr_reg] ? obj_rdata : 8'd0;
                    end
                    REG_DATA: begin
                        result.access_kind    = KIND_DATA_READ;
                        result.access_address = vptr_reg;
                        vptr_next             = vptr_reg + step;
                    end
                    default: begin
                        result.read_error = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase

        lvl = nmi_en_next & vbl_next;
        if (edge_chk) begin
            if (lvl && !nmi_prev_reg) begin
                nmi_cnt_next = NMI_CNT_W'(NMI_LAG);
            end
            nmi_prev_next = lvl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            last_reg      <= '0;
            temp_reg      <= '0;
            vptr_reg      <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            obj_ptr_reg   <= '0;
            vbl_reg       <= 1'b0;
            nmi_en_reg    <= 1'b0;
            nmi_prev_reg  <= 1'b0;
            nmi_cnt_reg   <= '0;
            obj_valid_reg <= '0;
        end else if (fire) begin
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            last_reg     <= last_next;
            temp_reg     <= temp_next;
            vptr_reg     <= vptr_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            obj_ptr_reg  <= obj_ptr_next;
            vbl_reg      <= vbl_next;
            nmi_en_reg   <= nmi_en_next;
            nmi_prev_reg <= nmi_prev_next;
            nmi_cnt_reg  <= nmi_cnt_next;
            if (obj_we) begin
                obj_valid_reg[obj_ptr_reg] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/prst_checker.sv */
`default_nettype none
`include "ppu_register_and_scroll_timing_unit_defines.svh"

module prst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [4:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [3:0]  m_tuser
);

    import prst_pkg::*;

    `PRST_ASSERT_AFTER_RESET(a_no_result_after_reset, aclk, aresetn, !m_tvalid)

    `PRST_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `PRST_ASSERT_NOW(a_error_without_access, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tuser[3:1] == KIND_NONE && m_tdata[7:0] == 8'd0)

    `PRST_ASSERT_NOW(a_idle_fields_zero, aclk, aresetn,
        m_tvalid && m_tuser[3:1] == KIND_NONE,
        m_tdata[31:8] == 24'd0 && m_tdata[36:34] == 3'd0)

    `PRST_ASSERT_NOW(a_attr_fetch_window, aclk, aresetn,
        m_tvalid && m_tuser[3:1] == KIND_AT_FETCH,
        m_tdata[23:20] == 4'b0010 && m_tdata[17:14] == 4'b1111 && m_tdata[34] == 1'b0)

endmodule

bind ppu_register_and_scroll_timing_unit prst_checker u_prst_checker (.*);

`default_nettype wire
